/* src/software_timer_slot_table_defines.svh */
// assertion macros for the timer slot table
`ifndef SOFTWARE_TIMER_SLOT_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define STST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define STST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STST_ASSERT(label, prop, msg)
`define STST_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* src/stst_pkg.sv */
// types and constants shared by the timer slot table
package stst_pkg;

	localparam int SLOTS     = 8;
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ID_W      = 32;
	localparam int TIME_W    = 32;
	localparam int TAG_W     = 16;
	localparam int KIND_W    = 2;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 56;

	typedef enum logic [KIND_W-1:0] {
		KIND_ONESHOT  = 2'd0,
		KIND_PERIODIC = 2'd1,
		KIND_CANCEL   = 2'd2,
		KIND_DISPATCH = 2'd3
	} kind_t;

	typedef enum logic [KIND_W-1:0] {
		RK_CREATE = 2'd0,
		RK_CANCEL = 2'd1,
		RK_FIRED  = 2'd2,
		RK_NONE   = 2'd3
	} rkind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] due;
		logic [TIME_W-1:0] period;
		logic [ID_W-1:0]   ident;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		rkind_t            kind;
		logic [ID_W-1:0]   id;
		logic              found;
		logic [TAG_W-1:0]  tag;
		logic              last;
	} result_t;

endpackage

/* src/stst_ram.sv */
// generic single-port-write ram with registered read
module stst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/stst_out.sv */
// result output register and stream packing
module stst_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  stst_pkg::result_t                   load_res,
	output logic                                free,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [stst_pkg::OUT_DATA_W-1:0]     m_tdata,  // timer_id, found, fired_tag, zero pad
	output logic [stst_pkg::KIND_W-1:0]         m_tuser,  // result_kind
	output logic                                m_tlast
);

	logic              valid_q;
	stst_pkg::result_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

	localparam int PAD_W = stst_pkg::OUT_DATA_W - stst_pkg::ID_W - 1 - stst_pkg::TAG_W;

	assign m_tvalid = valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, res_q.tag, res_q.found, res_q.id};
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;

endmodule

/* src/software_timer_slot_table.sv */
// top level of the timer slot table
// A table of SLOTS software timers. Slot contents (identity, period, due time, tag) live in
// one RAM with a registered read; in-use bits are flip-flops cleared by reset, so
// no clearing pass is needed and the block accepts words right after reset. A create
// writes the lowest free slot directly. A cancel scans the slots one per cycle through
// the RAM read port, waiting at its last step for a free output register, and ends at
// the first match or the last slot. A dispatch always scans all SLOTS slots, writing back
// advanced due times as it goes, then emits its final result. A new word is taken once the
// scan is done and the output register is free to take a result.
// start_time writes load the current time and take effect at once.
`include "software_timer_slot_table_defines.svh"

module software_timer_slot_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [stst_pkg::IN_DATA_W-1:0]      s_tdata,  // interval, identity, time_now, handler_tag
	input  logic [stst_pkg::KIND_W-1:0]         s_tuser,  // kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [stst_pkg::OUT_DATA_W-1:0]     m_tdata,  // timer_id, found, fired_tag, zero pad
	output logic [stst_pkg::KIND_W-1:0]         m_tuser,  // result_kind
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [stst_pkg::TIME_W-1:0]         cfg_data  // start_time
);

	localparam int IDX_W = stst_pkg::IDX_W;

	stst_pkg::state_t  state_q, state_d;
	stst_pkg::kind_t   op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [stst_pkg::ID_W-1:0]   key_q;
	logic [stst_pkg::ID_W-1:0]   id_q;
	logic [stst_pkg::TIME_W-1:0] now_q;
	logic [stst_pkg::SLOTS-1:0]  used_q;
	logic              hold_valid_q;
	stst_pkg::result_t hold_q;

	// input fields
	stst_pkg::kind_t             in_kind;
	logic [stst_pkg::TIME_W-1:0] in_interval;
	logic [stst_pkg::ID_W-1:0]   in_identity;
	logic [stst_pkg::TIME_W-1:0] in_time_now;
	logic [stst_pkg::TAG_W-1:0]  in_tag;

	assign in_kind     = stst_pkg::kind_t'(s_tuser);
	assign in_interval = s_tdata[31:0];
	assign in_identity = s_tdata[63:32];
	assign in_time_now = s_tdata[95:64];
	assign in_tag      = s_tdata[111:96];

	logic in_fire, is_create, out_free, out_load;
	stst_pkg::result_t out_res;

	logic ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	stst_pkg::entry_t ram_wdata, cur;

	logic [IDX_W-1:0] free_idx;
	logic full, cur_used, is_end, hit, fire, proceed, chk_step;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && s_tready;
	assign is_create = (in_kind == stst_pkg::KIND_ONESHOT) || (in_kind == stst_pkg::KIND_PERIODIC);

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = stst_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign full     = &used_q;
	assign cur_used = used_q[idx_q];
	assign is_end   = (idx_q == IDX_W'(stst_pkg::SLOTS - 1));
	assign hit      = cur_used && (cur.ident == key_q);
	assign fire     = cur_used && (cur.due < now_q);

	always_comb begin
		if (op_q == stst_pkg::KIND_CANCEL) begin
			proceed = (hit || is_end) ? out_free : 1'b1;
		end else begin
			proceed = (fire && hold_valid_q) ? out_free : 1'b1;
		end
	end

	assign chk_step = (state_q == stst_pkg::ST_CHK) && proceed;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stst_pkg::ST_IDLE: begin
				if (in_fire && !is_create) begin
					state_d = stst_pkg::ST_CHK;
				end
			end
			stst_pkg::ST_CHK: begin
				if (proceed) begin
					if (op_q == stst_pkg::KIND_CANCEL) begin
						if (hit || is_end) begin
							state_d = stst_pkg::ST_IDLE;
						end
					end else if (is_end) begin
						state_d = stst_pkg::ST_FLUSH;
					end
				end
			end
			stst_pkg::ST_FLUSH: begin
				if (out_free) begin
					state_d = stst_pkg::ST_IDLE;
				end
			end
			default: state_d = stst_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = 1'b0;
		out_load  = 1'b0;
		out_res   = '0;
		ram_we    = 1'b0;
		ram_waddr = free_idx;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			stst_pkg::ST_IDLE: begin
				s_tready = out_free;
				if (in_fire) begin
					if (is_create) begin
						out_load      = 1'b1;
						out_res.kind  = stst_pkg::RK_CREATE;
						out_res.id    = full ? '0 : id_q + 32'd1;
						out_res.found = !full;
						out_res.last  = 1'b1;
						ram_we           = !full;
						ram_wdata.ident  = id_q + 32'd1;
						ram_wdata.period = (in_kind == stst_pkg::KIND_PERIODIC) ? in_interval : '0;
						ram_wdata.due    = in_interval + now_q;
						ram_wdata.tag    = in_tag;
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			stst_pkg::ST_CHK: begin
				if (proceed) begin
					if (op_q == stst_pkg::KIND_CANCEL) begin
						if (hit || is_end) begin
							out_load      = 1'b1;
							out_res.kind  = stst_pkg::RK_CANCEL;
							out_res.id    = key_q;
							out_res.found = hit;
							out_res.last  = 1'b1;
						end
					end else if (fire) begin
						out_load      = hold_valid_q;
						out_res       = hold_q;
						ram_we        = (cur.period != '0);
						ram_waddr     = idx_q;
						ram_wdata     = cur;
						ram_wdata.due = cur.due + cur.period;
					end
					if (!is_end && !((op_q == stst_pkg::KIND_CANCEL) && hit)) begin
						ram_re    = 1'b1;
						ram_raddr = idx_q + IDX_W'(1);
					end
				end
			end
			stst_pkg::ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					if (hold_valid_q) begin
						out_res      = hold_q;
						out_res.last = 1'b1;
					end else begin
						out_res.kind = stst_pkg::RK_NONE;
						out_res.last = 1'b1;
					end
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= stst_pkg::ST_IDLE;
			op_q         <= stst_pkg::KIND_ONESHOT;
			idx_q        <= '0;
			id_q         <= '0;
			now_q        <= '0;
			used_q       <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				now_q <= cfg_data;
			end
			if (in_fire) begin
				op_q  <= in_kind;
				idx_q <= '0;
				if (is_create && !full) begin
					id_q             <= id_q + 32'd1;
					used_q[free_idx] <= 1'b1;
				end
				if (in_kind == stst_pkg::KIND_DISPATCH) begin
					now_q <= in_time_now;
				end
			end
			if (chk_step) begin
				if (!is_end) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (op_q == stst_pkg::KIND_CANCEL) begin
					if (hit) begin
						used_q[idx_q] <= 1'b0;
					end
				end else if (fire) begin
					hold_valid_q <= 1'b1;
					if (cur.period == '0) begin
						used_q[idx_q] <= 1'b0;
					end
				end
			end
			if ((state_q == stst_pkg::ST_FLUSH) && out_free) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q <= in_identity;
		end
		if (chk_step && (op_q == stst_pkg::KIND_DISPATCH) && fire) begin
			hold_q.kind  <= stst_pkg::RK_FIRED;
			hold_q.id    <= cur.ident;
			hold_q.found <= 1'b1;
			hold_q.tag   <= cur.tag;
			hold_q.last  <= 1'b0;
		end
	end

	stst_ram #(
		.WIDTH(stst_pkg::ENTRY_W),
		.DEPTH(stst_pkg::SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (cur)
	);

	stst_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.load_res (out_res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`STST_ASSERT(a_hold_idle, (state_q != stst_pkg::ST_IDLE) || !hold_valid_q, "fired word held while idle")
	`STST_ASSERT_NEXT(a_flush_ends, (state_q == stst_pkg::ST_FLUSH) && out_free, (state_q == stst_pkg::ST_IDLE) && m_tvalid && m_tlast, "dispatch did not end with a last word")
	`STST_ASSERT_NEXT(a_id_step, in_fire && is_create && !full, id_q == $past(id_q) + 32'd1, "identity counter did not advance on create")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the software timer slot table
module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_WORDS = 75;
	localparam int PHASES      = 6;

	typedef struct {
		stst_pkg::kind_t op;
		bit [31:0]       interval;
		bit [31:0]       ident;
		bit [31:0]       at_time;
		bit [15:0]       tag;
	} request_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [stst_pkg::IN_DATA_W-1:0]   s_tdata   = '0;
	logic [stst_pkg::KIND_W-1:0]      s_tuser   = '0;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [stst_pkg::OUT_DATA_W-1:0]  m_tdata;
	logic [stst_pkg::KIND_W-1:0]      m_tuser;
	logic                             m_tlast;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [stst_pkg::TIME_W-1:0]      cfg_data  = '0;

	software_timer_slot_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// timer table as the block should hold it
	bit        slot_busy [stst_pkg::SLOTS];
	bit [31:0] slot_id   [stst_pkg::SLOTS];
	bit [31:0] slot_step [stst_pkg::SLOTS];
	bit [31:0] slot_due  [stst_pkg::SLOTS];
	bit [15:0] slot_tag  [stst_pkg::SLOTS];
	bit [31:0] id_count  = '0;
	bit [31:0] clock_now = '0;

	request_t           request_queue [$];
	stst_pkg::result_t  answer_queue  [$];
	request_t           on_bus;
	int                 open_requests = 0;
	int                 fail_count    = 0;
	int                 quiet_cycles  = 0;
	bit                 calm          = 1'b0;
	bit                 in_taken      = 1'b0;
	bit [31:0]          cursor        = '0;

	function automatic bit rest_now();
		return !calm && ($urandom_range(99) < 9);
	endfunction

	function automatic request_t req(stst_pkg::kind_t op, bit [31:0] interval,
			bit [31:0] ident, bit [31:0] at_time, bit [15:0] tag);
		request_t r;
		r.op       = op;
		r.interval = interval;
		r.ident    = ident;
		r.at_time  = at_time;
		r.tag      = tag;
		return r;
	endfunction

	task automatic run_timer_request(input request_t r);
		stst_pkg::result_t a = '0;
		bit [31:0] fired_id  [$];
		bit [15:0] fired_tag [$];
		bit        done = 1'b0;
		a.last = 1'b1;
		case (r.op) inside
			stst_pkg::KIND_ONESHOT, stst_pkg::KIND_PERIODIC: begin
				a.kind = stst_pkg::RK_CREATE;
				for (int k = 0; k < stst_pkg::SLOTS; k++) begin
					if (!done && !slot_busy[k]) begin
						done = 1'b1;
						id_count++;
						slot_busy[k] = 1'b1;
						slot_id[k]   = id_count;
						slot_step[k] = (r.op == stst_pkg::KIND_PERIODIC) ? r.interval : 32'd0;
						slot_due[k]  = clock_now + r.interval;
						slot_tag[k]  = r.tag;
						a.id         = id_count;
						a.found      = 1'b1;
					end
				end
				answer_queue.push_back(a);
			end
			stst_pkg::KIND_CANCEL: begin
				a.kind = stst_pkg::RK_CANCEL;
				a.id   = r.ident;
				for (int k = 0; k < stst_pkg::SLOTS; k++) begin
					if (!done && slot_busy[k] && slot_id[k] == r.ident) begin
						done         = 1'b1;
						slot_busy[k] = 1'b0;
						a.found      = 1'b1;
					end
				end
				answer_queue.push_back(a);
			end
			default: begin
				clock_now = r.at_time;
				for (int k = 0; k < stst_pkg::SLOTS; k++) begin
					if (slot_busy[k] && slot_due[k] < r.at_time) begin
						fired_id.push_back(slot_id[k]);
						fired_tag.push_back(slot_tag[k]);
						if (slot_step[k] != 0)
							slot_due[k] = slot_due[k] + slot_step[k];
						else
							slot_busy[k] = 1'b0;
					end
				end
				if (fired_id.size() == 0) begin
					a.kind = stst_pkg::RK_NONE;
					answer_queue.push_back(a);
				end else begin
					for (int j = 0; j < fired_id.size(); j++) begin
						a.kind  = stst_pkg::RK_FIRED;
						a.id    = fired_id[j];
						a.found = 1'b1;
						a.tag   = fired_tag[j];
						a.last  = (j == fired_id.size() - 1);
						answer_queue.push_back(a);
					end
				end
			end
		endcase
	endtask

	task automatic flag_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s expected %h, got %h", $time, field, want, got);
		fail_count++;
	endtask

	// input side
	always @(posedge clk) begin
		in_taken = s_tvalid && s_tready;
		if (in_taken) begin
			run_timer_request(on_bus);
			open_requests--;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (in_taken || !s_tvalid)) begin
			if (request_queue.size() != 0 && !rest_now()) begin
				on_bus = request_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {on_bus.tag, on_bus.at_time, on_bus.ident, on_bus.interval};
				s_tuser  <= on_bus.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output side
	always @(negedge clk) m_tready <= !rest_now();

	always @(posedge clk) begin
		stst_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (answer_queue.size() == 0) begin
				$display("%0t: unexpected word kind %h id %h", $time, m_tuser, m_tdata[31:0]);
				fail_count++;
			end else begin
				want = answer_queue.pop_front();
				if (m_tuser !== want.kind)
					flag_mismatch("result_kind", 32'(want.kind), 32'(m_tuser));
				if (m_tdata[31:0] !== want.id)
					flag_mismatch("timer_id", want.id, m_tdata[31:0]);
				if (m_tdata[32] !== want.found)
					flag_mismatch("found", 32'(want.found), 32'(m_tdata[32]));
				if (m_tdata[48:33] !== want.tag)
					flag_mismatch("fired_tag", 32'(want.tag), 32'(m_tdata[48:33]));
				if (m_tdata[55:49] !== 7'd0)
					flag_mismatch("pad", 32'd0, 32'(m_tdata[55:49]));
				if (m_tlast !== want.last)
					flag_mismatch("last", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_request(input request_t r);
		while (request_queue.size() >= 2) @(negedge clk);
		request_queue.push_back(r);
		open_requests++;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (open_requests != 0 || answer_queue.size() != 0);
	endtask

	task automatic write_start(input bit [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		clock_now = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic make_random_request(output request_t r);
		int roll;
		roll       = $urandom_range(99);
		r.interval = $urandom;
		r.ident    = $urandom;
		r.at_time  = $urandom;
		r.tag      = 16'($urandom_range(16'hFFFF));
		if (roll < 22)
			r.op = stst_pkg::KIND_ONESHOT;
		else if (roll < 42)
			r.op = stst_pkg::KIND_PERIODIC;
		else if (roll < 62)
			r.op = stst_pkg::KIND_CANCEL;
		else
			r.op = stst_pkg::KIND_DISPATCH;
		roll = $urandom_range(9);
		case (r.op)
			stst_pkg::KIND_CANCEL: begin
				if (roll < 8)
					r.ident = id_count - $urandom_range(9) + $urandom_range(1);
			end
			stst_pkg::KIND_DISPATCH: begin
				if (roll < 8)
					cursor = cursor + $urandom_range(30);
				else if (roll == 8)
					cursor = $urandom;
				else
					cursor = cursor - $urandom_range(20);
				r.at_time = cursor;
			end
			default: begin
				if (roll == 0)
					r.interval = '0;
				else if (roll < 9)
					r.interval = $urandom_range(1, 50);
			end
		endcase
	endtask

	initial begin
		request_t  r;
		bit [31:0] starts [PHASES];
		starts = '{32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0, $urandom, 32'h8000_0000, $urandom};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// fill the table, then overflow it
		queue_request(req(stst_pkg::KIND_ONESHOT,  32'd0,         32'hFFFF_FFFF,
			32'hFFFF_FFFF, 16'h0000));
		queue_request(req(stst_pkg::KIND_PERIODIC, 32'd0,         32'h0,
			32'h0,         16'hFFFF));
		queue_request(req(stst_pkg::KIND_ONESHOT,  32'hFFFF_FFFF, 32'h5555_5555,
			32'hAAAA_AAAA, 16'hA5A5));
		queue_request(req(stst_pkg::KIND_PERIODIC, 32'd5,         32'hAAAA_AAAA,
			32'h5555_5555, 16'h0001));
		queue_request(req(stst_pkg::KIND_PERIODIC, 32'd1,         32'h0,
			32'hFFFF_FFFF, 16'h8000));
		queue_request(req(stst_pkg::KIND_ONESHOT,  32'd10,        32'hFFFF_FFFF,
			32'h0,         16'h1234));
		queue_request(req(stst_pkg::KIND_PERIODIC, 32'd100,       32'h0,
			32'h0,         16'h00FF));
		queue_request(req(stst_pkg::KIND_ONESHOT,  32'd7,         32'h0,
			32'h0,         16'hFF00));
		queue_request(req(stst_pkg::KIND_PERIODIC, 32'd3,         32'h0,
			32'h0,         16'h7777));
		// cancel hit, repeated cancel, misses
		queue_request(req(stst_pkg::KIND_CANCEL,   32'hFFFF_FFFF, 32'd6,
			32'hFFFF_FFFF, 16'hFFFF));
		queue_request(req(stst_pkg::KIND_CANCEL,   32'h0,         32'd6,
			32'h0,         16'h0));
		queue_request(req(stst_pkg::KIND_CANCEL,   32'h0,         32'hFFFF_FFFF,
			32'h0,         16'h0));
		queue_request(req(stst_pkg::KIND_CANCEL,   32'h0,         32'h0,
			32'h0,         16'h0));
		// due equal to now does not fire, zero period frees
		queue_request(req(stst_pkg::KIND_DISPATCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd0,         16'hFFFF));
		queue_request(req(stst_pkg::KIND_DISPATCH, 32'h0,         32'h0,
			32'd1,         16'h0));
		queue_request(req(stst_pkg::KIND_ONESHOT,  32'd2,         32'h0,
			32'h0,         16'h0F0F));
		// late periodic timers advance one period per dispatch
		queue_request(req(stst_pkg::KIND_DISPATCH, 32'h0, 32'h0, 32'd1000,      16'h0));
		queue_request(req(stst_pkg::KIND_DISPATCH, 32'h0, 32'h0, 32'd1000,      16'h0));
		queue_request(req(stst_pkg::KIND_DISPATCH, 32'h0, 32'h0, 32'hFFFF_FFFF, 16'h0));
		queue_request(req(stst_pkg::KIND_DISPATCH, 32'h0, 32'h0, 32'd0,         16'h0));
		for (int i = 3; i <= 7; i++)
			queue_request(req(stst_pkg::KIND_CANCEL, 32'h0, i, 32'h0, 16'h0));
		queue_request(req(stst_pkg::KIND_DISPATCH, 32'h0, 32'h0, 32'hFFFF_FFFF, 16'h0));
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			write_start(starts[p]);
			cursor = starts[p];
			calm   = (p == 2);
			if (p == 0) begin
				// due times wrap past zero
				queue_request(req(stst_pkg::KIND_PERIODIC, 32'h20, 32'h0, 32'h0, 16'h5A5A));
				queue_request(req(stst_pkg::KIND_ONESHOT,  32'h10, 32'h0, 32'h0, 16'hC3C3));
				queue_request(req(stst_pkg::KIND_DISPATCH, 32'h0,  32'h0, 32'h11, 16'h0));
				cursor = 32'h11;
			end
			repeat (PHASE_WORDS) begin
				make_random_request(r);
				queue_request(r);
			end
			wait_drained();
		end
		calm = 1'b0;

		repeat (4 * stst_pkg::SLOTS + 8) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/stst_pkg.sv
src/stst_ram.sv
src/stst_out.sv
src/software_timer_slot_table.sv
sim/testbench.sv
